>>> design/spp_pkg.sv
// Shared codes, widths and interface types of the star point projector.
package spp_pkg;

  localparam int QUOT_BITS = 25;
  localparam int QUOT_W    = QUOT_BITS + 1;
  localparam int NUM_W     = 96;
  localparam int DEN_W     = 66;
  localparam int DEPTH_MIN = 10738;

  typedef enum logic [1:0] {
    REQ_PLOT     = 2'd0,
    REQ_READ     = 2'd1,
    REQ_READ_CLR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_PLOTTED   = 2'd0,
    ST_BEHIND    = 2'd1,
    ST_OFFSCREEN = 2'd2,
    ST_READ      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_CAM_X = 3'd0,
    CFG_CAM_Y = 3'd1,
    CFG_CAM_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5,
    CFG_GAIN  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> design/spp_divider.sv
// Bit-serial restoring divider, quotient capped at 2^QUOT_BITS.
module spp_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spp_pkg::div_req_t req_i,
  output spp_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, done_q;
  logic [4:0]                    cnt_q;
  logic [spp_pkg::NUM_W-1:0]     rem_q, dsh_q;
  logic [spp_pkg::QUOT_W-1:0]    quo_q;
  logic                          ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= 5'(spp_pkg::QUOT_BITS);
      end else if (busy_q) begin
        if (cnt_q == 5'(spp_pkg::QUOT_BITS) && ge) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
          cnt_q  <= cnt_q - 5'd1;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= req_i.num;
      dsh_q <= spp_pkg::NUM_W'(req_i.den) << spp_pkg::QUOT_BITS;
      quo_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == 5'(spp_pkg::QUOT_BITS)) begin
        if (ge) quo_q[spp_pkg::QUOT_BITS] <= 1'b1;
      end else if (ge) begin
        rem_q        <= rem_q - dsh_q;
        quo_q[cnt_q] <= 1'b1;
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> design/spp_frame_mem.sv
// Framebuffer transparency memory with a clearing pass after reset.
module spp_frame_mem #(
  parameter int DEPTH  = 480000,
  parameter int ADDR_W = 19,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              clr_busy_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              clr_q;
  logic [ADDR_W-1:0] clr_ptr_q;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [DATA_W-1:0] wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_ptr_q <= '0;
    end else if (clr_q) begin
      if (clr_ptr_q == ADDR_W'(DEPTH - 1)) clr_q <= 1'b0;
      clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
    end
  end

  assign we = clr_q || wr_en_i;
  assign wa = clr_q ? clr_ptr_q : wr_addr_i;
  assign wd = clr_q ? {DATA_W{1'b1}} : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_q;

endmodule

>>> design/star_point_projector.sv
// Top level: star projection sequencer, config registers and result word.
// Projects star positions through a perspective camera into a framebuffer
// of SCREEN_WIDTH x SCREEN_HEIGHT transparency pixels, or reads (and
// optionally resets) one pixel. One word is handled at a time. A read issues
// its framebuffer read first and gives its result once the data is back. A
// plot runs four setup steps, three divisions (column, row, brightness) on
// one shared bit-serial divider, a bounds check, then a framebuffer
// read-modify-write. A star behind the camera is reported without any
// division, one off screen after the column and row divisions. A result the
// receiver has not taken holds the block until it is taken. After reset the
// framebuffer is swept to fully transparent, one pixel per cycle over all
// SCREEN_WIDTH*SCREEN_HEIGHT pixels (480000 by default); no input word is
// taken until the sweep ends, configuration writes are taken always.
module star_point_projector #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 600,
  parameter int ALPHA_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] star_x_i,
  input  logic [31:0] star_y_i,
  input  logic [31:0] star_z_i,
  input  logic [31:0] luminosity_i,
  input  logic [9:0]  read_col_i,
  input  logic [9:0]  pix_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  screen_col_o,
  output logic [9:0]  screen_row_o,
  output logic [15:0] transparency_o,
  output logic        was_overlap_o,
  output logic [31:0] plot_total_o,
  output logic [31:0] overlap_total_o
);

  localparam int PIX   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int IDX_W = $clog2(PIX);
  localparam int QW    = spp_pkg::QUOT_W;
  localparam int SH_R  = (ALPHA_BITS >= 16) ? ALPHA_BITS - 16 : 0;
  localparam int SH_L  = (ALPHA_BITS >= 16) ? 0 : 16 - ALPHA_BITS;
  localparam logic signed [13:0] W_S = 14'(SCREEN_WIDTH);
  localparam logic signed [13:0] H_S = 14'(SCREEN_HEIGHT);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_TRANS = 14'b00000000000010,
    S_MUL   = 14'b00000000000100,
    S_SUM   = 14'b00000000001000,
    S_SCALE = 14'b00000000010000,
    S_CS    = 14'b00000000100000,
    S_CW    = 14'b00000001000000,
    S_RS    = 14'b00000010000000,
    S_RW    = 14'b00000100000000,
    S_CHK   = 14'b00001000000000,
    S_AS    = 14'b00010000000000,
    S_AW    = 14'b00100000000000,
    S_PWR   = 14'b01000000000000,
    S_RD    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic signed [15:0] dir_x_q, dir_y_q, dir_z_q;
  logic        [23:0] gain_q;

  logic [1:0]         req_q;
  logic signed [31:0] sx_q, sy_q, sz_q;
  logic [31:0]        lum_q;
  logic [9:0]         rc_q, rr_q;

  logic signed [32:0] tx_q, ty_q, tz_q;
  logic [32:0]        mx, my, mz;
  logic signed [48:0] p_dx_q, p_dy_q, p_dz_q, p_hx_q, p_hy_q;
  logic [63:0]        sq_x_q, sq_y_q, sq_z_q;
  logic [55:0]        gl_q;
  logic signed [50:0] d_q;
  logic signed [49:0] h_q;
  logic signed [51:0] dh;
  logic signed [46:0] v;
  logic [spp_pkg::DEN_W-1:0] s_q, den2_q;
  logic [spp_pkg::NUM_W-1:0] numa_q;
  logic signed [65:0] cnum_q, rnum_q;
  logic [65:0]        cmag, rmag;
  logic [QW-1:0]      cq_q, rq_q, delta_q;
  logic               cneg_q, rneg_q, drop_q;
  logic [IDX_W-1:0]   pidx_q, ridx, rd_addr;
  logic               r_inrange, rd_en, wr_en;
  logic [ALPHA_BITS-1:0] rd_data, wr_data, new_a;
  logic [QW-1:0]      a_ext;

  spp_pkg::div_req_t  div_req;
  spp_pkg::div_rsp_t  div_rsp;
  logic               clr_busy, slot_free, emit;
  logic [1:0]         emit_status;

  logic        out_valid_q, ovl_q;
  logic [1:0]  status_q;
  logic [9:0]  col_q, row_q;
  logic [15:0] trans_q;
  logic [31:0] plot_cnt_q, ovl_cnt_q;

  function automatic logic [15:0] to16(input logic [ALPHA_BITS-1:0] a);
    logic [ALPHA_BITS+15:0] t;
    t = ({16'b0, a} << SH_L) >> SH_R;
    return t[15:0];
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= 32'hFFFF0000;
      cam_z_q <= '0;
      dir_x_q <= '0;
      dir_y_q <= 16'sd16384;
      dir_z_q <= '0;
      gain_q  <= 24'd10000;
    end else if (cfg_we_i) begin
      unique case (spp_pkg::cfg_idx_e'(cfg_idx_i))
        spp_pkg::CFG_CAM_X: cam_x_q <= cfg_wdata_i;
        spp_pkg::CFG_CAM_Y: cam_y_q <= cfg_wdata_i;
        spp_pkg::CFG_CAM_Z: cam_z_q <= cfg_wdata_i;
        spp_pkg::CFG_DIR_X: dir_x_q <= cfg_wdata_i[15:0];
        spp_pkg::CFG_DIR_Y: dir_y_q <= cfg_wdata_i[15:0];
        spp_pkg::CFG_DIR_Z: dir_z_q <= cfg_wdata_i[15:0];
        spp_pkg::CFG_GAIN:  gain_q  <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && !clr_busy;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign mx   = tx_q[32] ? 33'(-tx_q) : 33'(tx_q);
  assign my   = ty_q[32] ? 33'(-ty_q) : 33'(ty_q);
  assign mz   = tz_q[32] ? 33'(-tz_q) : 33'(tz_q);
  assign dh   = 52'(d_q) + 52'(h_q);
  assign v    = {tz_q, 14'b0};
  assign cmag = cnum_q[65] ? 66'(-cnum_q) : 66'(cnum_q);
  assign rmag = rnum_q[65] ? 66'(-rnum_q) : 66'(rnum_q);

  assign r_inrange = (13'(rc_q) < 13'(SCREEN_WIDTH)) && (13'(rr_q) < 13'(SCREEN_HEIGHT));
  assign ridx = IDX_W'(IDX_W'(rr_q) * IDX_W'(SCREEN_WIDTH) + IDX_W'(rc_q));

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = spp_pkg::NUM_W'(cmag);
    div_req.den   = den2_q;
    if (state_q == S_CS && !drop_q) div_req.start = 1'b1;
    if (state_q == S_RS) begin
      div_req.start = 1'b1;
      div_req.num   = spp_pkg::NUM_W'(rmag);
    end
    if (state_q == S_AS) begin
      div_req.start = 1'b1;
      div_req.num   = numa_q;
      div_req.den   = s_q;
    end
  end

  assign rd_en   = ((state_q == S_RD) && r_inrange) || ((state_q == S_AW) && div_rsp.done);
  assign rd_addr = (state_q == S_RD) ? ridx : pidx_q;

  assign a_ext = QW'(rd_data);
  assign new_a = (a_ext > delta_q) ? ALPHA_BITS'(a_ext - delta_q) : '0;

  always_comb begin
    state_d     = state_q;
    emit        = 1'b0;
    emit_status = spp_pkg::ST_READ;
    wr_en       = 1'b0;
    wr_data     = new_a;
    unique case (state_q)
      S_IDLE:  if (in_valid_i && in_ready_o) begin
                 state_d = (req_type_i != spp_pkg::REQ_PLOT) ? S_RD : S_TRANS;
               end
      S_TRANS: state_d = S_MUL;
      S_MUL:   state_d = S_SUM;
      S_SUM:   state_d = S_SCALE;
      S_SCALE: state_d = S_CS;
      S_CS:    state_d = drop_q ? S_CHK : S_CW;
      S_CW:    if (div_rsp.done) state_d = S_RS;
      S_RS:    state_d = S_RW;
      S_RW:    if (div_rsp.done) state_d = S_CHK;
      S_CHK: begin
        if (drop_q) begin
          emit_status = spp_pkg::ST_BEHIND;
          if (slot_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else if ((cneg_q && cq_q != '0) || cq_q >= QW'(SCREEN_WIDTH)
                     || (rneg_q && rq_q != '0) || rq_q >= QW'(SCREEN_HEIGHT)) begin
          emit_status = spp_pkg::ST_OFFSCREEN;
          if (slot_free) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_AS;
        end
      end
      S_AS:    state_d = S_AW;
      S_AW:    if (div_rsp.done) state_d = S_PWR;
      S_PWR: begin
        emit_status = spp_pkg::ST_PLOTTED;
        if (slot_free) begin
          emit    = 1'b1;
          wr_en   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        emit_status = spp_pkg::ST_READ;
        if (slot_free) begin
          emit    = 1'b1;
          wr_en   = r_inrange && (req_q == spp_pkg::REQ_READ_CLR);
          wr_data = {ALPHA_BITS{1'b1}};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // S_RD spends its first cycle issuing the read; the emit waits for data.
  logic rd_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_wait_q   <= 1'b0;
      out_valid_q <= 1'b0;
      plot_cnt_q  <= '0;
      ovl_cnt_q   <= '0;
    end else begin
      rd_wait_q <= (state_q == S_IDLE) && (state_d == S_RD);
      if (state_q == S_IDLE && state_d == S_RD) begin
        state_q <= S_RD;
      end else if (!(state_q == S_RD && rd_wait_q)) begin
        state_q <= state_d;
      end
      out_valid_q <= (emit && !(state_q == S_RD && rd_wait_q))
                     || (out_valid_q && !out_ready_i);
      if (emit && !(state_q == S_RD && rd_wait_q) && state_q == S_PWR) begin
        plot_cnt_q <= plot_cnt_q + 32'd1;
        if (rd_data != {ALPHA_BITS{1'b1}}) ovl_cnt_q <= ovl_cnt_q + 32'd1;
      end
    end
  end

  logic do_emit, do_write;
  assign do_emit  = emit && !(state_q == S_RD && rd_wait_q);
  assign do_write = wr_en && !(state_q == S_RD && rd_wait_q);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_type_i;
      sx_q  <= star_x_i;
      sy_q  <= star_y_i;
      sz_q  <= star_z_i;
      lum_q <= luminosity_i;
      rc_q  <= read_col_i;
      rr_q  <= pix_row_i;
    end
    if (state_q == S_TRANS) begin
      tx_q <= 33'(sx_q) - 33'(cam_x_q);
      ty_q <= 33'(sy_q) - 33'(cam_y_q);
      tz_q <= 33'(sz_q) - 33'(cam_z_q);
    end
    if (state_q == S_MUL) begin
      p_dx_q <= 49'(tx_q) * 49'(dir_x_q);
      p_dy_q <= 49'(ty_q) * 49'(dir_y_q);
      p_dz_q <= 49'(tz_q) * 49'(dir_z_q);
      p_hx_q <= 49'(tx_q) * 49'(dir_y_q);
      p_hy_q <= 49'(ty_q) * 49'(dir_x_q);
      sq_x_q <= 64'(mx * mx);
      sq_y_q <= 64'(my * my);
      sq_z_q <= 64'(mz * mz);
      gl_q   <= 56'(gain_q) * 56'(lum_q);
    end
    if (state_q == S_SUM) begin
      d_q    <= 51'(p_dx_q) + 51'(p_dy_q) + 51'(p_dz_q);
      h_q    <= 50'(p_hx_q) - 50'(p_hy_q);
      s_q    <= spp_pkg::DEN_W'(sq_x_q) + spp_pkg::DEN_W'(sq_y_q)
                + spp_pkg::DEN_W'(sq_z_q);
      numa_q <= spp_pkg::NUM_W'(gl_q) << (16 + ALPHA_BITS);
    end
    if (state_q == S_SCALE) begin
      drop_q <= d_q < 51'(spp_pkg::DEPTH_MIN);
      cnum_q <= 66'(dh) * 66'(W_S);
      rnum_q <= 66'(d_q) * 66'(H_S) + 66'(v) * 66'(W_S);
      den2_q <= spp_pkg::DEN_W'({d_q, 1'b0});
    end
    if (state_q == S_CW && div_rsp.done) begin
      cq_q   <= div_rsp.quo;
      cneg_q <= cnum_q[65];
    end
    if (state_q == S_RW && div_rsp.done) begin
      rq_q   <= div_rsp.quo;
      rneg_q <= rnum_q[65];
    end
    if (state_q == S_CHK) pidx_q <= IDX_W'(IDX_W'(rq_q) * IDX_W'(SCREEN_WIDTH) + IDX_W'(cq_q));
    if (state_q == S_AW && div_rsp.done) delta_q <= div_rsp.quo;
    if (do_emit) begin
      status_q <= emit_status;
      if (state_q == S_PWR) begin
        col_q   <= 10'(cq_q);
        row_q   <= 10'(rq_q);
        trans_q <= to16(new_a);
        ovl_q   <= rd_data != {ALPHA_BITS{1'b1}};
      end else if (state_q == S_RD) begin
        col_q   <= rc_q;
        row_q   <= rr_q;
        trans_q <= r_inrange ? to16(rd_data) : to16({ALPHA_BITS{1'b1}});
        ovl_q   <= 1'b0;
      end else begin
        col_q   <= '0;
        row_q   <= '0;
        trans_q <= '0;
        ovl_q   <= 1'b0;
      end
    end
  end

  spp_divider u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  spp_frame_mem #(
    .DEPTH  (PIX),
    .ADDR_W (IDX_W),
    .DATA_W (ALPHA_BITS)
  ) u_mem (
    .clk_i,
    .rst_ni,
    .rd_en_i    (rd_en && !(state_q == S_RD && !rd_wait_q)),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (do_write),
    .wr_addr_i  ((state_q == S_RD) ? ridx : pidx_q),
    .wr_data_i  (wr_data),
    .clr_busy_o (clr_busy)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign screen_col_o    = col_q;
  assign screen_row_o    = row_q;
  assign transparency_o  = trans_q;
  assign was_overlap_o   = ovl_q;
  assign plot_total_o    = plot_cnt_q;
  assign overlap_total_o = ovl_cnt_q;

`ifndef NO_ASSERTIONS
  a_plot_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (plot_cnt_q != $past(plot_cnt_q)) |-> $past(do_emit && state_q == S_PWR))
    else $error("plot count moved without a plot");

  a_ovl_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovl_cnt_q != $past(ovl_cnt_q)) |-> (plot_cnt_q != $past(plot_cnt_q)))
    else $error("overlap counted without a plot");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule

>>> verif/spp_checker.sv
// Checker: watches the star point projector channels, predicts each result word and compares.
module spp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] star_x_i,
  input  logic [31:0] star_y_i,
  input  logic [31:0] star_z_i,
  input  logic [31:0] luminosity_i,
  input  logic [9:0]  read_col_i,
  input  logic [9:0]  pix_row_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [9:0]  screen_col_i,
  input  logic [9:0]  screen_row_i,
  input  logic [15:0] transparency_i,
  input  logic        was_overlap_i,
  input  logic [31:0] plot_total_i,
  input  logic [31:0] overlap_total_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 800;
  localparam int H = 600;
  localparam logic [15:0] CLEAR = 16'hFFFF;

  typedef struct {
    spp_pkg::status_e st;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [15:0] trans;
    logic        ovl;
    logic [31:0] plots;
    logic [31:0] overlaps;
  } pixel_word_t;

  pixel_word_t        pixel_words_q[$];
  logic [15:0]        frame[0:W*H-1];
  logic [31:0]        plot_cnt, overlap_cnt;
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [23:0]        gain;
  int                 printed;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      fail_count_o++;
      if (printed < 40) $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
      printed++;
    end
  endtask

  function automatic pixel_word_t project_word();
    pixel_word_t r;
    longint tx, ty, tz, d, h, v, c, rw;
    logic [127:0] mx, my, mz, s, num, delta;
    logic [15:0] a;
    int idx;
    r = '{st: spp_pkg::ST_READ, col: 0, row: 0, trans: 0, ovl: 0, plots: 0, overlaps: 0};
    if (req_type_i != spp_pkg::REQ_PLOT) begin
      r.col = read_col_i;
      r.row = pix_row_i;
      r.trans = CLEAR;
      if (read_col_i < W && pix_row_i < H) begin
        idx = pix_row_i * W + read_col_i;
        r.trans = frame[idx];
        if (req_type_i == spp_pkg::REQ_READ_CLR) frame[idx] = CLEAR;
      end
    end else begin
      tx = longint'($signed(star_x_i)) - longint'(cam_x);
      ty = longint'($signed(star_y_i)) - longint'(cam_y);
      tz = longint'($signed(star_z_i)) - longint'(cam_z);
      d = tx * dir_x + ty * dir_y + tz * dir_z;
      h = tx * dir_y - ty * dir_x;
      v = tz * 16384;
      if (d < spp_pkg::DEPTH_MIN) begin
        r.st = spp_pkg::ST_BEHIND;
      end else begin
        c = (W * (d + h)) / (2 * d);
        rw = (H * d + W * v) / (2 * d);
        if (c < 0 || c >= W || rw < 0 || rw >= H) begin
          r.st = spp_pkg::ST_OFFSCREEN;
        end else begin
          idx = int'(rw * W + c);
          a = frame[idx];
          mx = (tx < 0) ? -tx : tx;
          my = (ty < 0) ? -ty : ty;
          mz = (tz < 0) ? -tz : tz;
          s = mx * mx + my * my + mz * mz;
          num = (128'(gain) * 128'(luminosity_i)) << 32;
          delta = num / s;
          if (delta > (128'(1) << spp_pkg::QUOT_BITS)) delta = 128'(1) << spp_pkg::QUOT_BITS;
          if (a != CLEAR) begin
            overlap_cnt++;
            r.ovl = 1'b1;
          end
          a = (128'(a) > delta) ? a - delta[15:0] : 16'd0;
          frame[idx] = a;
          plot_cnt++;
          r.st = spp_pkg::ST_PLOTTED;
          r.col = c[9:0];
          r.row = rw[9:0];
          r.trans = a;
        end
      end
    end
    r.plots = plot_cnt;
    r.overlaps = overlap_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < W * H; i++) frame[i] = CLEAR;
      plot_cnt = 0;
      overlap_cnt = 0;
      cam_x = 0;
      cam_y = -65536;
      cam_z = 0;
      dir_x = 0;
      dir_y = 16384;
      dir_z = 0;
      gain = 10000;
      fail_count_o = 0;
      printed = 0;
      pixel_words_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spp_pkg::CFG_CAM_X: cam_x = cfg_wdata_i;
          spp_pkg::CFG_CAM_Y: cam_y = cfg_wdata_i;
          spp_pkg::CFG_CAM_Z: cam_z = cfg_wdata_i;
          spp_pkg::CFG_DIR_X: dir_x = cfg_wdata_i[15:0];
          spp_pkg::CFG_DIR_Y: dir_y = cfg_wdata_i[15:0];
          spp_pkg::CFG_DIR_Z: dir_z = cfg_wdata_i[15:0];
          spp_pkg::CFG_GAIN:  gain = cfg_wdata_i[23:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pixel_words_q.size() == 0) begin
          report("unexpected word", 1, 0);
        end else begin
          want = pixel_words_q.pop_front();
          report("status", status_i, want.st);
          report("screen_col", screen_col_i, want.col);
          report("screen_row", screen_row_i, want.row);
          report("transparency", transparency_i, want.trans);
          report("was_overlap", was_overlap_i, want.ovl);
          report("plot_total", plot_total_i, want.plots);
          report("overlap_total", overlap_total_i, want.overlaps);
        end
      end
      if (in_valid_i && in_ready_i) pixel_words_q = {pixel_words_q, project_word()};
    end
    pending_o = pixel_words_q.size();
  end

endmodule

>>> verif/tb_star_point_projector.sv
// Testbench top: drives star plots, pixel reads and camera settings into the projector.
module tb_star_point_projector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_ALIAS_READ = 2'd3;
  localparam int         LIMIT = 3_000_000;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  logic        in_valid, in_ready;
  logic [1:0]  req_type;
  logic [31:0] star_x, star_y, star_z, luminosity;
  logic [9:0]  read_col, pix_row;
  logic        out_valid, out_ready;
  logic [1:0]  status;
  logic [9:0]  screen_col, screen_row;
  logic [15:0] transparency;
  logic        was_overlap;
  logic [31:0] plot_total, overlap_total;
  int          fail_count, pending;
  int          cycles, words_sent, words_got, settings;
  bit          quiet;
  int          ax_dx, ax_dy;
  longint      cx, cy, cz;

  star_point_projector dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .star_x_i(star_x), .star_y_i(star_y), .star_z_i(star_z),
    .luminosity_i(luminosity), .read_col_i(read_col), .pix_row_i(pix_row),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .screen_col_o(screen_col), .screen_row_o(screen_row),
    .transparency_o(transparency), .was_overlap_o(was_overlap),
    .plot_total_o(plot_total), .overlap_total_o(overlap_total)
  );

  spp_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .star_x_i(star_x), .star_y_i(star_y), .star_z_i(star_z),
    .luminosity_i(luminosity), .read_col_i(read_col), .pix_row_i(pix_row),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .screen_col_i(screen_col), .screen_row_i(screen_row),
    .transparency_i(transparency), .was_overlap_i(was_overlap),
    .plot_total_i(plot_total), .overlap_total_i(overlap_total),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (words_got == 300) stall = 1500;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      while (!out_valid) @(negedge clk);
      @(posedge clk);
      words_got++;
    end
  end

  task automatic send_word(logic [1:0] rq, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] lum, logic [9:0] col, logic [9:0] row);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    star_x <= x;
    star_y <= y;
    star_z <= z;
    luminosity <= lum;
    read_col <= col;
    pix_row <= row;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic program_cam(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                             logic [31:0] g);
    logic [31:0] vals[7];
    vals = '{vx, vy, vz, dx, dy, dz, g};
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= spp_pkg::cfg_idx_e'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cx = longint'($signed(vx));
    cy = longint'($signed(vy));
    cz = longint'($signed(vz));
    settings++;
  endtask

  // star at a given depth, lateral offset and height in camera terms
  task automatic plot_at(longint depth, longint lat, longint up, logic [31:0] lum);
    longint tx, ty;
    tx = depth * ax_dx + lat * ax_dy;
    ty = depth * ax_dy - lat * ax_dx;
    send_word(spp_pkg::REQ_PLOT, 32'(cx + tx), 32'(cy + ty), 32'(cz + up), lum, 0, 0);
  endtask

  function automatic logic [31:0] rand_lum();
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  function automatic logic [1:0] rand_read();
    case ($urandom_range(0, 2))
      0: return spp_pkg::REQ_READ;
      1: return spp_pkg::REQ_READ_CLR;
      default: return REQ_ALIAS_READ;
    endcase
  endfunction

  task automatic random_word(bit noise_only);
    int pick;
    longint depth, span;
    pick = $urandom_range(0, 99);
    depth = $urandom_range(8, 1 << 22);
    span = depth + depth / 4;
    if (noise_only && pick < 75) pick = 70;
    if (pick < 35)
      plot_at(depth, (depth >>> 3) * (longint'($urandom_range(0, 15)) - 8),
              (depth >>> 3) * (longint'($urandom_range(0, 11)) - 6), rand_lum());
    else if (pick < 60)
      plot_at(depth, longint'($urandom_range(0, 2 * span)) - span,
              longint'($urandom_range(0, 2 * depth)) - depth, rand_lum());
    else if (pick < 68)
      plot_at(-depth, longint'($urandom_range(0, 2 * depth)) - depth, 0, rand_lum());
    else if (pick < 75)
      send_word(spp_pkg::REQ_PLOT, $urandom(), $urandom(), $urandom(), $urandom(), 0, 0);
    else if (pick < 92)
      send_word(rand_read(), $urandom(), $urandom(), $urandom(), $urandom(),
                10'(400 + 50 * ($urandom_range(0, 15) - 8) + $urandom_range(0, 2) - 1),
                10'(300 + 50 * ($urandom_range(0, 11) - 6) + $urandom_range(0, 2) - 1));
    else
      send_word(rand_read(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
  endtask

  initial begin
    logic [31:0] g;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = spp_pkg::CFG_CAM_X;
    cfg_wdata = '0;
    in_valid = 1'b0;
    req_type = spp_pkg::REQ_PLOT;
    {star_x, star_y, star_z, luminosity} = '0;
    read_col = '0;
    pix_row = '0;
    quiet = 1'b0;
    ax_dx = 0;
    ax_dy = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    program_cam(0, -65536, 0, 0, 16384, 0, 10000);
    send_word(spp_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
    send_word(spp_pkg::REQ_READ_CLR, 0, 0, 0, 0, 799, 599);
    send_word(spp_pkg::REQ_READ, 0, 0, 0, 0, 800, 0);
    send_word(REQ_ALIAS_READ, 0, 0, 0, 0, 1023, 1023);
    plot_at(65536, 0, 0, 32'hFFFF_FFFF);
    plot_at(65536, 0, 0, 32'h0001_0000);
    send_word(spp_pkg::REQ_READ_CLR, 0, 0, 0, 0, 400, 300);
    send_word(spp_pkg::REQ_READ, 0, 0, 0, 0, 400, 300);
    plot_at(-65536, 0, 0, 32'h0001_0000);
    plot_at(0, 0, 0, 32'h0001_0000);
    plot_at(1, 0, 0, 32'h0001_0000);
    plot_at(65536, 131072, 0, 32'h0001_0000);
    plot_at(131072, 0, 0, 0);
    send_word(spp_pkg::REQ_PLOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 0, 0);
    send_word(spp_pkg::REQ_PLOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 0, 0);
    plot_at(1 << 20, -(1 << 20), -(3 << 18), 32'h0010_0000);
    plot_at(1 << 20, (1 << 20) - 1, (3 << 18) - 1, 32'h0010_0000);
    plot_at(1 << 20, (1 << 17) * 7, (1 << 17) * 5, 32'h0010_0000);
    plot_at(1 << 20, (1 << 17) * 7, (1 << 17) * 5, 32'h0010_0000);

    for (int p = 0; p < 15; p++) begin
      quiet = (p == 3);
      case (p % 4)
        0: begin ax_dx = 0; ax_dy = 1; end
        1: begin ax_dx = 1; ax_dy = 0; end
        2: begin ax_dx = 0; ax_dy = -1; end
        default: begin ax_dx = -1; ax_dy = 0; end
      endcase
      g = (p == 5) ? 32'd0 : (p == 6) ? 32'hFFFF_FFFF : $urandom_range(1, 1 << 20);
      if (p == 14) begin
        program_cam(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    {16'($urandom_range(0, 65535)), 16'h8000}, 32'h0000_7FFF, $urandom(),
                    32'h00FF_FFFF);
        for (int i = 0; i < 50; i++) random_word(1'b1);
      end else begin
        if (p == 13)
          program_cam($urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom(), $urandom(), $urandom(), g);
        else
          program_cam($urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom_range(0, 1 << 21) - (1 << 20),
                      $urandom_range(0, 1 << 21) - (1 << 20), 32'(16384 * ax_dx),
                      32'(16384 * ax_dy), 0, g);
        for (int i = 0; i < 100; i++) random_word(1'b0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d words (plots and pixel reads) under %0d camera settings,", words_sent,
             settings);
    $display("including a long result-side hold-off and a wide range of gains.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/spp_pkg.sv
design/spp_divider.sv
design/spp_frame_mem.sv
design/star_point_projector.sv
verif/spp_checker.sv
verif/tb_star_point_projector.sv
